// ===== rtl/fbpa_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fbpa_pkg
// Shared widths, codes and types of the fixed block pool allocator.
// ----------------------------------------------------------------------------
package fbpa_pkg;

  localparam int DEF_MAX_BLOCKS = 64;

  // Field widths
  localparam int REQ_W       = 16;
  localparam int IDX_PORT_W  = 6;
  localparam int BLK_CFG_W   = 7;
  localparam int BYTES_CFG_W = 16;
  localparam int TOTAL_W     = 22;
  localparam int SERIAL_W    = 32;
  localparam int LIVE_OUT_W  = 7;
  localparam int CFG_W       = 16;
  localparam int CFG_IDX_W   = 1;

  // Stream payload widths, padded to whole bytes
  localparam int IN_TDATA_W  = 24;
  localparam int OUT_TDATA_W = 96;

  // Register reset values
  localparam logic [BLK_CFG_W-1:0]   BLOCKS_RST = 7'd64;
  localparam logic [BYTES_CFG_W-1:0] BYTES_RST  = 16'd64;

  localparam logic [TOTAL_W-1:0] TOTAL_MAX = 22'h3F_FFFF;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_BLOCKS_IN_USE = 1'b0,
    REG_BLOCK_BYTES   = 1'b1
  } cfg_reg_t;

  typedef enum logic {
    OP_ALLOC = 1'b0,
    OP_FREE  = 1'b1
  } op_t;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_BUDGET   = 2'd1,
    ST_NO_FREE  = 2'd2,
    ST_BAD_FREE = 2'd3
  } status_t;

  typedef enum logic {
    S_IDLE   = 1'b0,
    S_LOOKUP = 1'b1
  } state_t;

  // Controller to datapath commands
  typedef struct packed {
    logic capture;  // latch request, start size store read
    logic commit;   // update state, load result register
  } cmd_t;

  // One result
  typedef struct packed {
    status_t                 status;
    logic [IDX_PORT_W-1:0]   granted_index;
    logic [SERIAL_W-1:0]     alloc_number;
    logic [TOTAL_W-1:0]      bytes_in_use;
    logic [TOTAL_W-1:0]      peak_bytes;
    logic [LIVE_OUT_W-1:0]   live_blocks;
    logic                    pool_full;
  } result_t;

endpackage

// ===== rtl/fixed_block_pool_allocator.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fixed_block_pool_allocator
// Pool allocator for equal-sized blocks with byte budget, peak and serials.
// ----------------------------------------------------------------------------
// A request has an accept and a lookup cycle: the accept cycle latches it,
// reads the stored size of the addressed block and forms the byte budget
// (block_bytes times active blocks); the lookup cycle runs the priority
// search over the in-use bitmap, checks the budget and commits. A new
// request is accepted the cycle after commit, so none is taken before the
// last one commits; a result left waiting in the output register holds the
// next request in lookup until it is taken. An allocate grants the lowest
// free block below the active count; a free of a block that is not in use
// answers status 3 and changes nothing. Write configuration only while idle.
// The per-block size store comes up undefined and needs no clearing pass.
module fixed_block_pool_allocator #(
  parameter int MAX_BLOCKS = fbpa_pkg::DEF_MAX_BLOCKS
) (
  input  logic                              clk,
  input  logic                              rst_n,
  // Request stream
  input  logic                              in_tvalid,
  output logic                              in_tready,
  // [15:0] request_bytes, [21:16] block_index, [23:22] zero
  input  logic [fbpa_pkg::IN_TDATA_W-1:0]   in_tdata,
  // [0] operation
  input  logic                              in_tuser,
  // Result stream
  output logic                              out_tvalid,
  input  logic                              out_tready,
  // [5:0] granted_index, [37:6] alloc_number, [59:38] bytes_in_use,
  // [81:60] peak_bytes, [88:82] live_blocks, [89] pool_full, [95:90] zero
  output logic [fbpa_pkg::OUT_TDATA_W-1:0]  out_tdata,
  // [1:0] status
  output logic [1:0]                        out_tuser,
  // Configuration write port
  input  logic                              cfg_wr_en,
  input  logic [fbpa_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [fbpa_pkg::CFG_W-1:0]        cfg_wdata
);
  import fbpa_pkg::*;

  localparam int OUT_USED_W = IDX_PORT_W + SERIAL_W + 2 * TOTAL_W + LIVE_OUT_W + 1;

  cmd_t    cmd;
  result_t result;

  fbpa_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .cmd        (cmd)
  );

  // Unpack the request fields straight into the datapath
  fbpa_datapath #(
    .MAX_BLOCKS (MAX_BLOCKS)
  ) u_datapath (
    .clk        (clk),
    .rst_n      (rst_n),
    .cmd        (cmd),
    .req_op     (in_tuser),
    .req_bytes  (in_tdata[REQ_W-1:0]),
    .req_index  (in_tdata[REQ_W+IDX_PORT_W-1:REQ_W]),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata),
    .result     (result)
  );

  // Pack the result, first field in the lowest bits
  assign out_tdata = {
    (OUT_TDATA_W - OUT_USED_W)'(0),
    result.pool_full,
    result.live_blocks,
    result.peak_bytes,
    result.bytes_in_use,
    result.alloc_number,
    result.granted_index
  };
  assign out_tuser = result.status;

endmodule

// ===== rtl/fbpa_ctrl.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fbpa_ctrl
// Two-state sequencer: capture a request, then commit it once the result
// register is free. Owns the result valid flag.
// ----------------------------------------------------------------------------
module fbpa_ctrl (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_tvalid,
  output logic          in_tready,
  output logic          out_tvalid,
  input  logic          out_tready,
  output fbpa_pkg::cmd_t cmd
);
  import fbpa_pkg::*;

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (in_tvalid) state_nxt = S_LOOKUP;
      end
      S_LOOKUP: begin
        if (!out_valid_r || out_tready) state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    in_tready   = 1'b0;
    cmd.capture = 1'b0;
    cmd.commit  = 1'b0;
    case (state_r)
      S_IDLE: begin
        in_tready   = 1'b1;
        cmd.capture = in_tvalid;
      end
      S_LOOKUP: begin
        cmd.commit = !out_valid_r || out_tready;
      end
      default: ;
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (cmd.commit)      out_valid_nxt = 1'b1;
    else if (out_tready) out_valid_nxt = 1'b0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign out_tvalid = out_valid_r;

`ifndef SYNTHESIS
  // A request waits in lookup while the previous result is not taken.
  a_hold_lookup: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_LOOKUP && out_valid_r && !out_tready |=> state_r == S_LOOKUP)
    else $error("request left lookup while result register blocked");

  // An accepted request is always followed by a lookup cycle.
  a_capture_lookup: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.capture |=> state_r == S_LOOKUP && !in_tready)
    else $error("accepted request not followed by lookup");
`endif

endmodule

// ===== rtl/fbpa_datapath.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fbpa_datapath
// Pool state, size store, free-block search, budget check and result register.
// ----------------------------------------------------------------------------
module fbpa_datapath #(
  parameter int MAX_BLOCKS = fbpa_pkg::DEF_MAX_BLOCKS
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  fbpa_pkg::cmd_t                   cmd,
  input  logic                             req_op,
  input  logic [fbpa_pkg::REQ_W-1:0]       req_bytes,
  input  logic [fbpa_pkg::IDX_PORT_W-1:0]  req_index,
  input  logic                             cfg_wr_en,
  input  logic [fbpa_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [fbpa_pkg::CFG_W-1:0]       cfg_wdata,
  output fbpa_pkg::result_t                result
);
  import fbpa_pkg::*;

  localparam int IDX_W   = (MAX_BLOCKS > 1) ? $clog2(MAX_BLOCKS) : 1;
  localparam int CNT_RAW = $clog2(MAX_BLOCKS + 1);
  localparam int CNT_W   = (CNT_RAW > BLK_CFG_W) ? CNT_RAW : BLK_CFG_W;
  localparam int BUD_W   = BYTES_CFG_W + CNT_W;
  localparam int WANT_W  = TOTAL_W + 1;
  localparam int CMP_W   = (BUD_W > WANT_W) ? BUD_W : WANT_W;

  // Configuration
  logic [BLK_CFG_W-1:0]   blocks_cfg_r;
  logic [BYTES_CFG_W-1:0] bytes_cfg_r;

  // Pool state
  logic [MAX_BLOCKS-1:0]  used_map_r, used_map_nxt;
  logic [TOTAL_W-1:0]     byte_total_r, byte_total_nxt;
  logic [TOTAL_W-1:0]     byte_peak_r, byte_peak_nxt;
  logic [CNT_W-1:0]       live_count_r, live_count_nxt;
  logic [SERIAL_W-1:0]    serial_r;

  // Size store
  logic [REQ_W-1:0]       size_mem [MAX_BLOCKS];
  logic [REQ_W-1:0]       size_rd_r;

  // Captured request
  logic                   op_r;
  logic [REQ_W-1:0]       req_r;
  logic [IDX_W-1:0]       idx_r;
  logic                   idx_ok_r;
  logic [BUD_W-1:0]       budget_r;

  logic [CNT_W-1:0]       act;
  logic [MAX_BLOCKS-1:0]  free_vec;
  logic                   found;
  logic [IDX_W-1:0]       grant;
  logic [WANT_W-1:0]      want;
  logic                   over;
  logic                   idx_used;
  logic                   alloc_ok;
  logic                   free_ok;
  status_t                status;

  // Active block count, saturated to the pool size
  assign act = (CNT_W'(blocks_cfg_r) > CNT_W'(MAX_BLOCKS)) ? CNT_W'(MAX_BLOCKS)
                                                            : CNT_W'(blocks_cfg_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      blocks_cfg_r <= BLOCKS_RST;
      bytes_cfg_r  <= BYTES_RST;
    end else if (cfg_wr_en) begin
      case (cfg_reg_t'(cfg_index))
        REG_BLOCKS_IN_USE: blocks_cfg_r <= cfg_wdata[BLK_CFG_W-1:0];
        REG_BLOCK_BYTES:   bytes_cfg_r  <= cfg_wdata[BYTES_CFG_W-1:0];
        default: ;
      endcase
    end
  end

  // Capture request and precompute the byte budget
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      op_r     <= req_op;
      req_r    <= req_bytes;
      idx_r    <= IDX_W'(req_index);
      idx_ok_r <= (32'(req_index) < MAX_BLOCKS);
      budget_r <= BUD_W'(bytes_cfg_r) * BUD_W'(act);
    end
  end

  // Size store: read on capture, write on a granted allocate
  always_ff @(posedge clk) begin
    if (cmd.capture) size_rd_r <= size_mem[IDX_W'(req_index)];
    if (cmd.commit && alloc_ok) size_mem[grant] <= req_r;
  end

  // Lowest free active block
  always_comb begin
    for (int i = 0; i < MAX_BLOCKS; i++) begin
      free_vec[i] = !used_map_r[i] && (CNT_W'(i) < act);
    end
  end

  always_comb begin
    found = 1'b0;
    grant = '0;
    for (int i = MAX_BLOCKS - 1; i >= 0; i--) begin
      if (free_vec[i]) begin
        found = 1'b1;
        grant = IDX_W'(i);
      end
    end
  end

  assign want     = WANT_W'(req_r) + WANT_W'(byte_total_r);
  assign over     = want[WANT_W-1] || (CMP_W'(want) > CMP_W'(budget_r));
  assign idx_used = idx_ok_r && used_map_r[idx_r];

  always_comb begin
    alloc_ok = 1'b0;
    free_ok  = 1'b0;
    status   = ST_OK;
    if (op_r == OP_ALLOC) begin
      if (over)        status = ST_BUDGET;
      else if (!found) status = ST_NO_FREE;
      else             alloc_ok = 1'b1;
    end else begin
      if (!idx_used) status = ST_BAD_FREE;
      else           free_ok = 1'b1;
    end
  end

  always_comb begin
    used_map_nxt   = used_map_r;
    byte_total_nxt = byte_total_r;
    byte_peak_nxt  = byte_peak_r;
    live_count_nxt = live_count_r;
    if (alloc_ok) begin
      used_map_nxt[grant] = 1'b1;
      byte_total_nxt      = want[TOTAL_W-1:0];
      if (want[TOTAL_W-1:0] > byte_peak_r) byte_peak_nxt = want[TOTAL_W-1:0];
      live_count_nxt      = live_count_r + CNT_W'(1);
    end else if (free_ok) begin
      used_map_nxt[idx_r] = 1'b0;
      byte_total_nxt = (byte_total_r >= TOTAL_W'(size_rd_r))
                     ? byte_total_r - TOTAL_W'(size_rd_r) : '0;
      if (live_count_r != '0) live_count_nxt = live_count_r - CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      used_map_r   <= '0;
      byte_total_r <= '0;
      byte_peak_r  <= '0;
      live_count_r <= '0;
      serial_r     <= '0;
    end else if (cmd.commit) begin
      used_map_r   <= used_map_nxt;
      byte_total_r <= byte_total_nxt;
      byte_peak_r  <= byte_peak_nxt;
      live_count_r <= live_count_nxt;
      if (alloc_ok) serial_r <= serial_r + SERIAL_W'(1);
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (cmd.commit) begin
      result.status        <= status;
      result.granted_index <= alloc_ok ? IDX_PORT_W'(grant) : '0;
      result.alloc_number  <= alloc_ok ? serial_r : '0;
      result.bytes_in_use  <= byte_total_nxt;
      result.peak_bytes    <= byte_peak_nxt;
      result.live_blocks   <= LIVE_OUT_W'(live_count_nxt);
      result.pool_full     <= (live_count_nxt == act);
    end
  end

`ifndef SYNTHESIS
  a_live_matches_map: assert property (@(posedge clk) disable iff (!rst_n)
    32'(live_count_r) == $countones(used_map_r))
    else $error("live count out of step with in-use bitmap");

  a_peak_covers_total: assert property (@(posedge clk) disable iff (!rst_n)
    byte_peak_r >= byte_total_r)
    else $error("byte peak below byte total");

  a_peak_monotonic: assert property (@(posedge clk) disable iff (!rst_n)
    $past(rst_n) |-> byte_peak_r >= $past(byte_peak_r))
    else $error("byte peak decreased");
`endif

endmodule

// ===== sim/fixed_block_pool_allocator_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fixed_block_pool_allocator_tb
// Self-checking bench for the fixed block pool allocator.
// ----------------------------------------------------------------------------
// Drives allocate and free requests over the input stream and checks every
// response against a cycle-free model of the pool: in-use bitmap, stored
// request sizes, byte total and peak, live count and allocation serial.
// A short directed table covers the corner cases, then random phases run
// under changing pool settings with bursty input and a stalling receiver.
// ----------------------------------------------------------------------------
module fixed_block_pool_allocator_tb;
  import fbpa_pkg::*;

  localparam int DIR_ROWS     = 24;
  localparam int PHASES       = 9;
  localparam int PHASE_ITEMS  = 50;
  localparam int QUIET_LIMIT  = 2000;
  localparam int LONG_HOLD    = 300;
  localparam int SETTLE_TICKS = 4;

  typedef enum logic {
    ROW_REQ = 1'b0,
    ROW_CFG = 1'b1
  } row_kind_t;

  // One row of the directed table. For request rows, data is request_bytes;
  // for register rows, data is the value written to reg_sel.
  typedef struct {
    row_kind_t             kind;
    op_t                   op;
    cfg_reg_t              reg_sel;
    logic [15:0]           data;
    logic [IDX_PORT_W-1:0] idx;
    logic                  typed;
    result_t               res;
  } dir_row_t;

  localparam result_t NO_RESULT = '0;

  // --------------------------------------------------------------------------
  // Clock, reset and block ports
  // --------------------------------------------------------------------------
  logic clk   = 1'b0;
  logic rst_n = 1'b0;

  logic                   in_tvalid = 1'b0;
  logic                   in_tready;
  logic [IN_TDATA_W-1:0]  in_tdata  = '0;
  logic                   in_tuser  = 1'b0;
  logic                   out_tvalid;
  logic                   out_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] out_tdata;
  logic [1:0]             out_tuser;
  logic                   cfg_wr_en = 1'b0;
  logic [CFG_IDX_W-1:0]   cfg_index = '0;
  logic [CFG_W-1:0]       cfg_wdata = '0;

  always #2 clk = ~clk;

  fixed_block_pool_allocator uut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    // [15:0] request_bytes, [21:16] block_index, [23:22] zero
    .in_tdata   (in_tdata),
    // [0] operation
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    // [5:0] granted_index, [37:6] alloc_number, [59:38] bytes_in_use,
    // [81:60] peak_bytes, [88:82] live_blocks, [89] pool_full, [95:90] zero
    .out_tdata  (out_tdata),
    // [1:0] status
    .out_tuser  (out_tuser),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata)
  );

  // --------------------------------------------------------------------------
  // Pool model: its own copy of the registers and the pool state
  // --------------------------------------------------------------------------
  logic [BLK_CFG_W-1:0]   cfg_blocks = BLOCKS_RST;
  logic [BYTES_CFG_W-1:0] cfg_bytes  = BYTES_RST;

  logic [63:0]            pool_used   = '0;
  logic [REQ_W-1:0]       pool_size [64];
  logic [TOTAL_W-1:0]     pool_total  = '0;
  logic [TOTAL_W-1:0]     pool_peak   = '0;
  logic [LIVE_OUT_W-1:0]  pool_live   = '0;
  logic [SERIAL_W-1:0]    pool_serial = '0;

  result_t pending_responses [$];
  result_t next_response;
  int      errors          = 0;
  int      responses_seen  = 0;
  int      quiet_cycles    = 0;

  // Apply one request to the pool model and return the response it owes.
  function automatic result_t pool_response(op_t op, logic [REQ_W-1:0] req,
                                            logic [IDX_PORT_W-1:0] idx);
    result_t          r;
    logic [6:0]       act;
    longint unsigned  budget;
    longint unsigned  want;
    int               slot;
    r    = '0;
    slot = -1;
    // Active count saturates at the pool size
    act    = (cfg_blocks > 7'd64) ? 7'd64 : cfg_blocks;
    budget = longint'(cfg_bytes) * longint'(act);
    if (op == OP_ALLOC) begin
      want = longint'(req) + longint'(pool_total);
      // Budget check wins over the free-block check
      if (want > budget || want > longint'(TOTAL_MAX)) begin
        r.status = ST_BUDGET;
      end else begin
        for (int i = 0; i < 64; i++) begin
          if (slot < 0 && i < act && !pool_used[i]) slot = i;
        end
        if (slot < 0) begin
          r.status = ST_NO_FREE;
        end else begin
          r.status        = ST_OK;
          r.granted_index = slot[IDX_PORT_W-1:0];
          r.alloc_number  = pool_serial;
          pool_used[slot] = 1'b1;
          pool_size[slot] = req;
          pool_serial     = pool_serial + 32'd1;
          pool_total      = want[TOTAL_W-1:0];
          if (pool_total > pool_peak) pool_peak = pool_total;
          pool_live       = pool_live + 7'd1;
        end
      end
    end else begin
      // A block outside the active range may still be freed
      if (!pool_used[idx]) begin
        r.status = ST_BAD_FREE;
      end else begin
        r.status       = ST_OK;
        pool_used[idx] = 1'b0;
        pool_total     = (pool_total >= pool_size[idx]) ? pool_total - pool_size[idx] : '0;
        if (pool_live != 0) pool_live = pool_live - 7'd1;
      end
    end
    r.bytes_in_use = pool_total;
    r.peak_bytes   = pool_peak;
    r.live_blocks  = pool_live;
    r.pool_full    = (pool_live == act);
    return r;
  endfunction

  // --------------------------------------------------------------------------
  // Sender side
  // --------------------------------------------------------------------------
  // Offer one request, hold it until taken, then queue what it owes. A typed
  // row queues its hand-written response; the model still advances.
  task automatic send_request(op_t op, logic [REQ_W-1:0] req,
                              logic [IDX_PORT_W-1:0] idx,
                              logic typed, result_t res);
    result_t predicted;
    @(negedge clk);
    in_tvalid <= 1'b1;
    in_tdata  <= {2'b00, idx, req};
    in_tuser  <= op;
    do @(posedge clk); while (!in_tready);
    predicted = pool_response(op, req, idx);
    pending_responses.push_back(typed ? res : predicted);
  endtask

  // Drop valid for a gap whose length is set by n.
  task automatic pause_sender(int n);
    @(negedge clk);
    in_tvalid <= 1'b0;
    repeat (n - 1) @(negedge clk);
  endtask

  // Drop valid and hold off until every owed response is back and the block
  // has had time to go idle.
  task automatic settle_idle();
    @(negedge clk);
    in_tvalid <= 1'b0;
    while (pending_responses.size() != 0) @(posedge clk);
    repeat (SETTLE_TICKS) @(posedge clk);
  endtask

  task automatic write_reg(cfg_reg_t sel, logic [CFG_W-1:0] value);
    @(negedge clk);
    cfg_wr_en <= 1'b1;
    cfg_index <= sel;
    cfg_wdata <= value;
    @(posedge clk);
    if (sel == REG_BLOCKS_IN_USE) cfg_blocks = value[BLK_CFG_W-1:0];
    else cfg_bytes = value[BYTES_CFG_W-1:0];
    @(negedge clk);
    cfg_wr_en <= 1'b0;
  endtask

  // --------------------------------------------------------------------------
  // Receiver side: its own stall pattern, plus one long hold-off that backs
  // the block up until it stops taking requests
  // --------------------------------------------------------------------------
  initial begin
    int rx_mode;
    int rx_left;
    bit long_hold_done;
    rx_mode        = 0;
    rx_left        = 0;
    long_hold_done = 1'b0;
    forever begin
      @(negedge clk);
      if (!long_hold_done && responses_seen >= 60) begin
        out_tready <= 1'b0;
        repeat (LONG_HOLD) @(negedge clk);
        long_hold_done = 1'b1;
      end else begin
        if (rx_left == 0) begin
          rx_mode = $urandom_range(0, 3);
          rx_left = $urandom_range(16, 96);
        end
        rx_left--;
        case (rx_mode)
          0: begin
            out_tready <= 1'b1;
          end
          1: begin
            out_tready <= 1'($urandom_range(0, 1));
          end
          2: begin
            out_tready <= ($urandom_range(0, 9) != 0);
          end
          default: begin
            out_tready <= ~out_tready;
          end
        endcase
      end
    end
  end

  // --------------------------------------------------------------------------
  // Response checker
  // --------------------------------------------------------------------------
  task automatic check_field(string name, logic [31:0] want, logic [31:0] got);
    if (want !== got) begin
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
      errors++;
    end
  endtask

  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) begin
      responses_seen++;
      if (pending_responses.size() == 0) begin
        $display("%0t: response with none owed, expected none, actual status %0d",
                 $time, out_tuser);
        errors++;
      end else begin
        next_response = pending_responses.pop_front();
        check_field("status",        32'(next_response.status),
                    32'(out_tuser));
        check_field("granted_index", 32'(next_response.granted_index),
                    32'(out_tdata[5:0]));
        check_field("alloc_number",  next_response.alloc_number,
                    out_tdata[37:6]);
        check_field("bytes_in_use",  32'(next_response.bytes_in_use),
                    32'(out_tdata[59:38]));
        check_field("peak_bytes",    32'(next_response.peak_bytes),
                    32'(out_tdata[81:60]));
        check_field("live_blocks",   32'(next_response.live_blocks),
                    32'(out_tdata[88:82]));
        check_field("pool_full",     32'(next_response.pool_full),
                    32'(out_tdata[89]));
      end
    end
  end

  // Watchdog: end the run once nothing has moved for too long
  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) quiet_cycles <= 0;
      else quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= QUIET_LIMIT) begin
        $display("%0t: no request or response moved for %0d cycles", $time, quiet_cycles);
        $display("Regression FAIL");
        $finish;
      end
    end
  end

  // --------------------------------------------------------------------------
  // Stimulus
  // --------------------------------------------------------------------------
  dir_row_t dir_rows [DIR_ROWS];

  initial begin
    int               burst_left;
    int               alloc_pct;
    int               pick;
    int               used_list [$];
    logic [CFG_W-1:0] new_blocks;
    logic [CFG_W-1:0] new_bytes;
    op_t              op;
    logic [REQ_W-1:0] req;
    logic [5:0]       idx;

    // Directed table. Typed responses follow the model by hand; the rest
    // go through the pool model.
    dir_rows = '{
      // two active blocks of 100 bytes
      '{ROW_CFG, OP_ALLOC, REG_BLOCKS_IN_USE, 16'd2,     6'd0,  1'b0, NO_RESULT},
      '{ROW_CFG, OP_ALLOC, REG_BLOCK_BYTES,   16'd100,   6'd0,  1'b0, NO_RESULT},
      '{ROW_REQ, OP_ALLOC, REG_BLOCKS_IN_USE, 16'd0,     6'd0,  1'b1,
        '{ST_OK, 6'd0, 32'd0, 22'd0, 22'd0, 7'd1, 1'b0}},
      '{ROW_REQ, OP_ALLOC, REG_BLOCKS_IN_USE, 16'd100,   6'd0,  1'b1,
        '{ST_OK, 6'd1, 32'd1, 22'd100, 22'd100, 7'd2, 1'b1}},
      // pool full but budget left: no free block
      '{ROW_REQ, OP_ALLOC, REG_BLOCKS_IN_USE, 16'd0,     6'd0,  1'b1,
        '{ST_NO_FREE, 6'd0, 32'd0, 22'd100, 22'd100, 7'd2, 1'b1}},
      // over budget and no free block: budget reported
      '{ROW_REQ, OP_ALLOC, REG_BLOCKS_IN_USE, 16'd101,   6'd0,  1'b1,
        '{ST_BUDGET, 6'd0, 32'd0, 22'd100, 22'd100, 7'd2, 1'b1}},
      // free of a block never granted
      '{ROW_REQ, OP_FREE,  REG_BLOCKS_IN_USE, 16'd0,     6'd5,  1'b1,
        '{ST_BAD_FREE, 6'd0, 32'd0, 22'd100, 22'd100, 7'd2, 1'b1}},
      '{ROW_REQ, OP_FREE,  REG_BLOCKS_IN_USE, 16'd0,     6'd1,  1'b1,
        '{ST_OK, 6'd0, 32'd0, 22'd0, 22'd100, 7'd1, 1'b0}},
      '{ROW_REQ, OP_ALLOC, REG_BLOCKS_IN_USE, 16'hFFFF,  6'd0,  1'b0, NO_RESULT},
      // no active blocks: zero budget, block 0 still granted from before
      '{ROW_CFG, OP_ALLOC, REG_BLOCKS_IN_USE, 16'd0,     6'd0,  1'b0, NO_RESULT},
      '{ROW_REQ, OP_ALLOC, REG_BLOCKS_IN_USE, 16'd1,     6'd0,  1'b1,
        '{ST_BUDGET, 6'd0, 32'd0, 22'd0, 22'd100, 7'd1, 1'b0}},
      '{ROW_REQ, OP_ALLOC, REG_BLOCKS_IN_USE, 16'd0,     6'd0,  1'b1,
        '{ST_NO_FREE, 6'd0, 32'd0, 22'd0, 22'd100, 7'd1, 1'b0}},
      '{ROW_REQ, OP_FREE,  REG_BLOCKS_IN_USE, 16'd0,     6'd0,  1'b1,
        '{ST_OK, 6'd0, 32'd0, 22'd0, 22'd100, 7'd0, 1'b1}},
      // active count above the pool size saturates; largest block size
      '{ROW_CFG, OP_ALLOC, REG_BLOCKS_IN_USE, 16'd127,   6'd0,  1'b0, NO_RESULT},
      '{ROW_CFG, OP_ALLOC, REG_BLOCK_BYTES,   16'hFFFF,  6'd0,  1'b0, NO_RESULT},
      '{ROW_REQ, OP_ALLOC, REG_BLOCKS_IN_USE, 16'hFFFF,  6'd0,  1'b1,
        '{ST_OK, 6'd0, 32'd2, 22'd65535, 22'd65535, 7'd1, 1'b0}},
      '{ROW_REQ, OP_ALLOC, REG_BLOCKS_IN_USE, 16'd0,     6'd0,  1'b0, NO_RESULT},
      '{ROW_REQ, OP_FREE,  REG_BLOCKS_IN_USE, 16'hFFFF,  6'd63, 1'b0, NO_RESULT},
      // shrink the budget below what is already held
      '{ROW_CFG, OP_ALLOC, REG_BLOCKS_IN_USE, 16'd64,    6'd0,  1'b0, NO_RESULT},
      '{ROW_CFG, OP_ALLOC, REG_BLOCK_BYTES,   16'd1,     6'd0,  1'b0, NO_RESULT},
      '{ROW_REQ, OP_ALLOC, REG_BLOCKS_IN_USE, 16'd1,     6'd0,  1'b0, NO_RESULT},
      '{ROW_REQ, OP_FREE,  REG_BLOCKS_IN_USE, 16'd0,     6'd0,  1'b0, NO_RESULT},
      '{ROW_REQ, OP_FREE,  REG_BLOCKS_IN_USE, 16'd0,     6'd1,  1'b0, NO_RESULT},
      '{ROW_REQ, OP_ALLOC, REG_BLOCKS_IN_USE, 16'd1,     6'd0,  1'b0, NO_RESULT}
    };
    burst_left = 0;

    // Hold reset, then release it on a falling edge
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Walk the directed table back to back
    foreach (dir_rows[i]) begin
      if (dir_rows[i].kind == ROW_CFG) begin
        settle_idle();
        write_reg(dir_rows[i].reg_sel, dir_rows[i].data);
      end else begin
        send_request(dir_rows[i].op, dir_rows[i].data, dir_rows[i].idx,
                     dir_rows[i].typed, dir_rows[i].res);
      end
    end

    // Random phases: drain, retune the pool, then a run of requests
    for (int phase = 0; phase < PHASES; phase++) begin
      settle_idle();
      case (phase)
        0: begin
          new_blocks = 16'd64;
          new_bytes  = 16'hFFFF;
        end
        1: begin
          new_blocks = 16'd1;
          new_bytes  = 16'd1;
        end
        2: begin
          new_blocks = CFG_W'($urandom_range(65, 127));
          new_bytes  = CFG_W'($urandom_range(1, 300));
        end
        default: begin
          case ($urandom_range(0, 7))
            0: new_blocks = 16'd1;
            1: new_blocks = 16'd64;
            2: new_blocks = 16'd0;
            3: new_blocks = CFG_W'($urandom_range(65, 127));
            default: new_blocks = CFG_W'($urandom_range(1, 64));
          endcase
          case ($urandom_range(0, 7))
            0: new_bytes = 16'd1;
            1: new_bytes = 16'hFFFF;
            2: new_bytes = 16'd0;
            3: new_bytes = CFG_W'($urandom_range(0, 65535));
            default: new_bytes = CFG_W'($urandom_range(1, 256));
          endcase
        end
      endcase
      write_reg(REG_BLOCKS_IN_USE, new_blocks);
      write_reg(REG_BLOCK_BYTES, new_bytes);
      // Fill hard in the first phase: most of its requests are allocates
      alloc_pct = (phase == 0) ? 85 : $urandom_range(35, 75);

      for (int n = 0; n < PHASE_ITEMS; n++) begin
        // Bursts of random length; a zero gap keeps the stream running
        if (burst_left == 0) begin
          pick = $urandom_range(0, 9);
          if (pick >= 4) pause_sender((pick == 9) ? $urandom_range(10, 25)
                                                   : $urandom_range(1, 6));
          burst_left = $urandom_range(1, 16);
        end
        burst_left--;

        idx = 6'($urandom_range(0, 63));
        req = REQ_W'($urandom_range(0, 65535));
        if ($urandom_range(0, 99) < alloc_pct) begin
          op = OP_ALLOC;
          case ($urandom_range(0, 9))
            0: req = '0;
            1: req = 16'hFFFF;
            2: ;
            default: req = REQ_W'($urandom_range(0, cfg_bytes));
          endcase
        end else begin
          op = OP_FREE;
          // Mostly release a block that is held; otherwise any index
          used_list.delete();
          for (int b = 0; b < 64; b++) if (pool_used[b]) used_list.push_back(b);
          if (used_list.size() != 0 && $urandom_range(0, 99) < 85)
            idx = 6'(used_list[$urandom_range(0, used_list.size() - 1)]);
        end
        send_request(op, req, idx, 1'b0, NO_RESULT);
      end
    end

    // Drain and let the block go quiet before the verdict
    @(negedge clk);
    in_tvalid <= 1'b0;
    while (pending_responses.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);
    if (errors == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
rtl/fbpa_pkg.sv
rtl/fbpa_ctrl.sv
rtl/fbpa_datapath.sv
rtl/fixed_block_pool_allocator.sv
sim/fixed_block_pool_allocator_tb.sv
